@@ hdl/spll_pkg.sv @@
// ----------------------------------------------------------------------------
// spll_pkg
// Shared types and constants for the slot pool with free and used lists.
// ----------------------------------------------------------------------------
package spll_pkg;

    localparam int DEPTH     = 16;
    localparam int DATA_BITS = 32;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LINK_W    = $clog2(DEPTH + 1);

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(DEPTH);

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_BAD_REMOVE = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] data_word;
        logic [3:0]  slot_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] result_slot;
        logic [4:0] used_count;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic exec;
        logic find_step;
        logic put;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_kind;
        logic       find_done;
        logic       out_busy;
    } t_stat;

endpackage

@@ hdl/slot_pool_linked_list.sv @@
// Add, remove and unknown kinds run a single execute step; a find walks the
// used list from its head, at most DEPTH slots, with one data RAM read per slot.
// The result is put in the output register once that register is free.
// One item at a time: the next transfer is taken only after the result has
// entered the output register.
// Reset: free list 0..DEPTH-1, no slot used.
// ----------------------------------------------------------------------------
// slot_pool_linked_list
// Fixed slot pool with a LIFO free list and a doubly linked used list.
// ----------------------------------------------------------------------------
module slot_pool_linked_list (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  spll_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output spll_pkg::t_out_item o_out_item
);

    spll_pkg::t_cmd  cmd;
    spll_pkg::t_stat stat;

    spll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    spll_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

@@ hdl/spll_ram.sv @@
// ----------------------------------------------------------------------------
// spll_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module spll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/spll_ctrl.sv @@
// ----------------------------------------------------------------------------
// spll_ctrl
// Sequencer: accepts one item, runs it on the datapath, hands off the result.
// ----------------------------------------------------------------------------
module spll_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  spll_pkg::t_stat i_stat,
    output spll_pkg::t_cmd  o_cmd,
    output logic          o_in_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIND,
        S_PUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   n_in_stall;
    spll_pkg::t_cmd cmd;

    always_comb begin
        n_state    = r_state;
        n_in_stall = r_in_stall;
        cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_in_stall) begin
                    cmd.load   = 1'b1;
                    n_in_stall = 1'b1;
                    n_state    = (i_stat.in_kind == spll_pkg::KIND_FIND) ? S_FIND : S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                n_state  = S_PUT;
            end
            S_FIND: begin
                cmd.find_step = 1'b1;
                if (i_stat.find_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!i_stat.out_busy) begin
                    cmd.put    = 1'b1;
                    n_in_stall = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_stall = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = r_in_stall;

endmodule

@@ hdl/spll_dp.sv @@
// ----------------------------------------------------------------------------
// spll_dp
// Datapath: link tables, list heads, data RAM, list walk and result register.
// ----------------------------------------------------------------------------
module spll_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spll_pkg::t_cmd      i_cmd,
    input  spll_pkg::t_in_item  i_in_item,
    input  logic                i_out_stall,
    output spll_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    output spll_pkg::t_out_item o_out_item
);

    localparam int IDX_W  = spll_pkg::IDX_W;
    localparam int LINK_W = spll_pkg::LINK_W;
    localparam int DBITS  = spll_pkg::DATA_BITS;

    logic [LINK_W-1:0] r_next [spll_pkg::DEPTH];
    logic [LINK_W-1:0] r_prev [spll_pkg::DEPTH];
    logic [spll_pkg::DEPTH-1:0] r_in_use;
    logic [LINK_W-1:0] r_used_head;
    logic [LINK_W-1:0] r_free_head;
    logic [LINK_W-1:0] r_total;

    logic [1:0]        r_kind;
    logic [31:0]       r_data;
    logic [3:0]        r_idx;

    logic [LINK_W-1:0] r_cur;
    logic [IDX_W-1:0]  r_cur_q;
    logic [LINK_W-1:0] r_steps;
    logic              r_pend;

    logic [1:0]        r_res_status;
    logic [3:0]        r_res_slot;
    logic              r_out_valid;
    spll_pkg::t_out_item r_out_item;

    logic [DBITS-1:0]  ram_rdata;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_raddr;

    logic [IDX_W-1:0]  fh_i;
    logic [IDX_W-1:0]  uh_i;
    logic [IDX_W-1:0]  rm_i;
    logic [IDX_W-1:0]  cur_i;
    logic              fh_ok;
    logic              uh_ok;
    logic              rm_ok;
    logic [LINK_W-1:0] rm_prev;
    logic [LINK_W-1:0] rm_next;
    logic              can_issue;
    logic              match;

    assign fh_i    = r_free_head[IDX_W-1:0];
    assign uh_i    = r_used_head[IDX_W-1:0];
    assign rm_i    = r_idx[IDX_W-1:0];
    assign cur_i   = r_cur[IDX_W-1:0];
    assign fh_ok   = r_free_head < spll_pkg::NIL_LINK;
    assign uh_ok   = r_used_head < spll_pkg::NIL_LINK;
    assign rm_ok   = (32'(r_idx) < 32'(spll_pkg::DEPTH)) && r_in_use[rm_i];
    assign rm_prev = r_prev[rm_i];
    assign rm_next = r_next[rm_i];

    assign can_issue = (r_cur < spll_pkg::NIL_LINK) && (r_steps < LINK_W'(spll_pkg::DEPTH));
    assign match     = r_pend && (ram_rdata == r_data[DBITS-1:0]);

    assign ram_we    = i_cmd.exec && (r_kind == spll_pkg::KIND_ADD) && fh_ok;
    assign ram_waddr = fh_i;
    assign ram_raddr = cur_i;

    spll_ram #(
        .WIDTH (DBITS),
        .DEPTH (spll_pkg::DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_data[DBITS-1:0]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < spll_pkg::DEPTH; i++) begin
                r_next[i] <= LINK_W'(i + 1);
                r_prev[i] <= spll_pkg::NIL_LINK;
            end
            r_in_use    <= '0;
            r_used_head <= spll_pkg::NIL_LINK;
            r_free_head <= '0;
            r_total     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_kind  <= i_in_item.kind;
                r_data  <= i_in_item.data_word;
                r_idx   <= i_in_item.slot_index;
                r_cur   <= r_used_head;
                r_steps <= '0;
                r_pend  <= 1'b0;
            end

            if (i_cmd.exec) begin
                r_res_status <= spll_pkg::ST_OK;
                r_res_slot   <= '0;
                case (r_kind)
                    spll_pkg::KIND_ADD: begin
                        if (!fh_ok) begin
                            r_res_status <= spll_pkg::ST_FULL;
                        end else begin
                            r_free_head    <= r_next[fh_i];
                            r_next[fh_i]   <= r_used_head;
                            r_prev[fh_i]   <= spll_pkg::NIL_LINK;
                            if (uh_ok) begin
                                r_prev[uh_i] <= r_free_head;
                            end
                            r_used_head    <= r_free_head;
                            r_in_use[fh_i] <= 1'b1;
                            r_total        <= r_total + 1'b1;
                            r_res_slot     <= 4'(r_free_head);
                        end
                    end
                    spll_pkg::KIND_REMOVE: begin
                        if (!rm_ok) begin
                            r_res_status <= spll_pkg::ST_BAD_REMOVE;
                        end else begin
                            if (rm_prev < spll_pkg::NIL_LINK) begin
                                r_next[rm_prev[IDX_W-1:0]] <= rm_next;
                            end else begin
                                r_used_head <= rm_next;
                            end
                            if (rm_next < spll_pkg::NIL_LINK) begin
                                r_prev[rm_next[IDX_W-1:0]] <= rm_prev;
                            end
                            r_next[rm_i]   <= r_free_head;
                            r_prev[rm_i]   <= spll_pkg::NIL_LINK;
                            r_free_head    <= LINK_W'(rm_i);
                            r_in_use[rm_i] <= 1'b0;
                            if (r_total != '0) begin
                                r_total <= r_total - 1'b1;
                            end
                        end
                    end
                    default: begin
                        r_res_status <= spll_pkg::ST_OK;
                    end
                endcase
            end

            if (i_cmd.find_step) begin
                if (match) begin
                    r_res_status <= spll_pkg::ST_OK;
                    r_res_slot   <= 4'(r_cur_q);
                end else if (!can_issue) begin
                    r_res_status <= spll_pkg::ST_NOT_FOUND;
                    r_res_slot   <= '0;
                end else begin
                    r_cur   <= r_next[cur_i];
                    r_cur_q <= cur_i;
                    r_steps <= r_steps + 1'b1;
                    r_pend  <= 1'b1;
                end
            end

            if (i_cmd.put) begin
                r_out_valid            <= 1'b1;
                r_out_item.status      <= r_res_status;
                r_out_item.result_slot <= r_res_slot;
                r_out_item.used_count  <= 5'(r_total);
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.in_kind   = i_in_item.kind;
    assign o_stat.find_done = match || !can_issue;
    assign o_stat.out_busy  = r_out_valid && i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out_item;

endmodule

@@ dv/tb_slot_pool_linked_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_pool_linked_list
// Self-checking bench for the slot pool. A queue of planned operations feeds a
// falling-edge driver. Remove targets and find keys can be chosen from the live
// pool just before each transfer. Every input transfer updates a shadow pool
// that predicts the result. A rising-edge monitor compares each output
// transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_slot_pool_linked_list;

    localparam logic [1:0] KIND_IGNORED = 2'd3;
    localparam int RANDOM_OPS   = 1000;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 4 + spll_pkg::DEPTH + 12;

    typedef enum logic [1:0] {
        AIM_AS_IS,
        AIM_LIVE_SLOT,
        AIM_LIVE_KEY,
        AIM_DRAIN
    } t_aim;

    typedef struct packed {
        spll_pkg::t_in_item item;
        t_aim               aim;
    } t_plan;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    spll_pkg::t_in_item  i_in_item   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    spll_pkg::t_out_item o_out_item;

    // shadow pool
    logic [spll_pkg::DATA_BITS-1:0] slot_word [spll_pkg::DEPTH];
    logic [spll_pkg::LINK_W-1:0]    link_fwd  [spll_pkg::DEPTH];
    logic [spll_pkg::LINK_W-1:0]    link_back [spll_pkg::DEPTH];
    bit                             slot_busy [spll_pkg::DEPTH];
    logic [spll_pkg::LINK_W-1:0]    busy_head;
    logic [spll_pkg::LINK_W-1:0]    spare_head;
    int                             busy_total;

    t_plan               plan_q[$];
    spll_pkg::t_out_item outcome_q[$];
    bit        in_took;
    int        taken_total;
    int        phase_len;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        quiet_cycles;
    bit        stuck;
    int        mismatches;

    slot_pool_linked_list dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic spll_pkg::t_out_item pool_apply(spll_pkg::t_in_item op);
        spll_pkg::t_out_item         res;
        logic [spll_pkg::LINK_W-1:0] s;
        logic [spll_pkg::LINK_W-1:0] p;
        logic [spll_pkg::LINK_W-1:0] n;
        int                          steps;
        res = '0;
        case (op.kind)
            spll_pkg::KIND_ADD: begin
                s = spare_head;
                if (s < spll_pkg::DEPTH) begin
                    spare_head = link_fwd[s];
                    slot_word[s] = op.data_word;
                    link_fwd[s] = busy_head;
                    link_back[s] = spll_pkg::NIL_LINK;
                    if (busy_head < spll_pkg::DEPTH) link_back[busy_head] = s;
                    busy_head = s;
                    slot_busy[s] = 1'b1;
                    busy_total++;
                    res.result_slot = spll_pkg::IDX_W'(s);
                end else begin
                    res.status = spll_pkg::ST_FULL;
                end
            end
            spll_pkg::KIND_REMOVE: begin
                s = spll_pkg::LINK_W'(op.slot_index);
                if (s >= spll_pkg::DEPTH || !slot_busy[s]) begin
                    res.status = spll_pkg::ST_BAD_REMOVE;
                end else begin
                    p = link_back[s];
                    n = link_fwd[s];
                    if (p < spll_pkg::DEPTH) link_fwd[p] = n;
                    else busy_head = n;
                    if (n < spll_pkg::DEPTH) link_back[n] = p;
                    link_fwd[s] = spare_head;
                    link_back[s] = spll_pkg::NIL_LINK;
                    spare_head = s;
                    slot_busy[s] = 1'b0;
                    if (busy_total > 0) busy_total--;
                end
            end
            spll_pkg::KIND_FIND: begin
                res.status = spll_pkg::ST_NOT_FOUND;
                s = busy_head;
                for (steps = 0; steps < spll_pkg::DEPTH && s < spll_pkg::DEPTH; steps++) begin
                    if (slot_word[s] == op.data_word) begin
                        res.status = spll_pkg::ST_OK;
                        res.result_slot = spll_pkg::IDX_W'(s);
                        break;
                    end
                    s = link_fwd[s];
                end
            end
            default: ;
        endcase
        res.used_count = 5'(busy_total);
        return res;
    endfunction

    // fill in a live slot or a live key from the shadow pool, if any slot is used
    function automatic spll_pkg::t_in_item settle(t_plan p);
        spll_pkg::t_in_item it;
        int                 live;
        int                 k;
        int                 i;
        it = p.item;
        live = -1;
        if (p.aim != AIM_AS_IS && busy_total > 0) begin
            k = $urandom_range(0, busy_total - 1);
            for (i = 0; i < spll_pkg::DEPTH; i++) begin
                if (slot_busy[i] && live < 0) begin
                    if (k == 0) live = i;
                    else k--;
                end
            end
        end
        if (live >= 0) begin
            if (p.aim == AIM_LIVE_SLOT) it.slot_index = spll_pkg::IDX_W'(live);
            else it.data_word = slot_word[live];
        end
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 32'($urandom_range(0, 7));
        if (r < 50) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    task automatic queue_op(input logic [1:0] kind, input logic [31:0] word,
                            input logic [3:0] idx, input t_aim aim);
        t_plan p;
        p.item.kind = kind;
        p.item.data_word = word;
        p.item.slot_index = idx;
        p.aim = aim;
        plan_q.push_back(p);
    endtask

    task automatic queue_drain();
        queue_op(KIND_IGNORED, '0, '0, AIM_DRAIN);
    endtask

    // driver: one update per falling edge, a stalled transfer is held as is
    always @(negedge i_clk) begin : feeder
        logic               v;
        spll_pkg::t_in_item it;
        t_plan              head;
        v = i_in_valid;
        it = i_in_item;
        if (taken_total < phase_len) begin
            send_idle_pct = 36;
            recv_idle_pct = 88;
        end else if (taken_total < 2 * phase_len) begin
            send_idle_pct = 88;
            recv_idle_pct = 36;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (in_took) begin
            v = 1'b0;
            in_took = 1'b0;
        end
        if (i_rst_n && !v && plan_q.size() > 0) begin
            if (plan_q[0].aim == AIM_DRAIN) begin
                if (outcome_q.size() == 0) head = plan_q.pop_front();
            end else if ($urandom_range(0, 99) >= send_idle_pct) begin
                head = plan_q.pop_front();
                it = settle(head);
                v = 1'b1;
            end
        end
        i_in_valid <= v;
        i_in_item <= it;
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // monitor: outputs first so a stray result is never paired with a new request
    always @(posedge i_clk) begin : watch
        spll_pkg::t_out_item want;
        bit                  moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (outcome_q.size() == 0) begin
                    $error("result with nothing pending: status %0d slot %0d count %0d",
                           o_out_item.status, o_out_item.result_slot,
                           o_out_item.used_count);
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, o_out_item.status);
                        mismatches++;
                    end
                    if (o_out_item.result_slot !== want.result_slot) begin
                        $error("result_slot: expected %0d, got %0d",
                               want.result_slot, o_out_item.result_slot);
                        mismatches++;
                    end
                    if (o_out_item.used_count !== want.used_count) begin
                        $error("used_count: expected %0d, got %0d",
                               want.used_count, o_out_item.used_count);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                outcome_q.push_back(pool_apply(i_in_item));
                in_took = 1'b1;
                taken_total++;
            end
            if (moved) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) stuck = 1'b1;
        end
    end

    initial begin
        logic [31:0] fill_words [16];
        int          i;
        int          n;
        int          tide;
        int          r;
        fill_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                       32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_1234,
                       32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0002, 32'h0000_0003,
                       32'h0000_1234, 32'h0000_0004, 32'h0000_0005, 32'h0000_0006};
        for (i = 0; i < spll_pkg::DEPTH; i++) begin
            slot_word[i] = '0;
            link_fwd[i] = spll_pkg::LINK_W'(i + 1);
            link_back[i] = spll_pkg::NIL_LINK;
            slot_busy[i] = 1'b0;
        end
        link_fwd[spll_pkg::DEPTH-1] = spll_pkg::NIL_LINK;
        busy_head = spll_pkg::NIL_LINK;
        spare_head = '0;
        busy_total = 0;

        // empty pool: miss, bad removes at both ends of the index range, ignored kind
        queue_op(spll_pkg::KIND_FIND, 32'hDEAD_BEEF, 4'd0, AIM_AS_IS);
        queue_op(spll_pkg::KIND_REMOVE, '0, 4'd0, AIM_AS_IS);
        queue_op(spll_pkg::KIND_REMOVE, '0, 4'd15, AIM_AS_IS);
        queue_op(KIND_IGNORED, 32'hFFFF_FFFF, 4'd15, AIM_AS_IS);
        for (i = 0; i < spll_pkg::DEPTH; i++) begin
            queue_op(spll_pkg::KIND_ADD, fill_words[i], 4'd0, AIM_AS_IS);
        end
        queue_op(spll_pkg::KIND_ADD, 32'h1111_1111, 4'd0, AIM_AS_IS);
        // tail of the used list, duplicate key, full-length miss
        queue_op(spll_pkg::KIND_FIND, 32'h0000_0000, 4'd0, AIM_AS_IS);
        queue_op(spll_pkg::KIND_FIND, 32'h0000_1234, 4'd0, AIM_AS_IS);
        queue_op(spll_pkg::KIND_FIND, 32'hCAFE_F00D, 4'd0, AIM_AS_IS);
        // middle, head, tail unlink, then LIFO reuse
        queue_op(spll_pkg::KIND_REMOVE, '0, 4'd7, AIM_AS_IS);
        queue_op(spll_pkg::KIND_REMOVE, '0, 4'd15, AIM_AS_IS);
        queue_op(spll_pkg::KIND_REMOVE, '0, 4'd0, AIM_AS_IS);
        queue_op(spll_pkg::KIND_ADD, 32'h00C0_FFEE, 4'd0, AIM_AS_IS);
        queue_op(spll_pkg::KIND_FIND, 32'hFFFF_FFFF, 4'd0, AIM_AS_IS);
        queue_drain();

        tide = 75;
        for (n = 0; n < RANDOM_OPS; n++) begin
            if (n % 50 == 0) tide = ((n / 50) % 2 == 0) ? $urandom_range(15, 30)
                                                       : $urandom_range(65, 85);
            if (n % 250 == 249) queue_drain();
            r = $urandom_range(0, 99);
            if (r < 3) begin
                queue_op(KIND_IGNORED, $urandom, 4'($urandom_range(0, 15)), AIM_AS_IS);
            end else begin
                r = $urandom_range(0, 99);
                if (r < tide) begin
                    queue_op(spll_pkg::KIND_ADD, rand_word(), 4'($urandom_range(0, 15)),
                             AIM_AS_IS);
                end else if (r < tide + (100 - tide) / 2) begin
                    queue_op(spll_pkg::KIND_REMOVE, $urandom, 4'($urandom_range(0, 15)),
                             ($urandom_range(0, 99) < 85) ? AIM_LIVE_SLOT : AIM_AS_IS);
                end else begin
                    queue_op(spll_pkg::KIND_FIND, rand_word(), 4'($urandom_range(0, 15)),
                             ($urandom_range(0, 99) < 65) ? AIM_LIVE_KEY : AIM_AS_IS);
                end
            end
        end
        phase_len = plan_q.size() / 3;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!stuck && (plan_q.size() != 0 || i_in_valid || outcome_q.size() != 0))
            @(negedge i_clk);
        if (!stuck) repeat (TAIL_CYCLES) @(negedge i_clk);

        if (!stuck && mismatches == 0 && outcome_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/spll_pkg.sv
hdl/spll_ram.sv
hdl/spll_ctrl.sv
hdl/spll_dp.sv
hdl/slot_pool_linked_list.sv
dv/tb_slot_pool_linked_list.sv
